// File: hw/rtl/mst_pkg.sv
`default_nettype none

package mst_pkg;

    // action codes carried on s_tuser
    localparam logic [2:0] ACT_TOUCH            = 3'd0;
    localparam logic [2:0] ACT_RELEASE          = 3'd1;
    localparam logic [2:0] ACT_CLEAR_ACTIVE     = 3'd2;
    localparam logic [2:0] ACT_RELEASE_INACTIVE = 3'd3;
    localparam logic [2:0] ACT_RELEASE_ALL      = 3'd4;

    localparam int ACTION_W = 3;
    localparam int FINGER_W = 32;
    localparam int COORD_W  = 16;
    localparam int SLOT_W   = 4;

    // at most this many result beats per input beat
    localparam int RESULT_LIMIT = 16;
    localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);

    localparam int IN_DATA_W  = FINGER_W + 2 * COORD_W;
    localparam int OUT_DATA_W = ((SLOT_W + 2 * COORD_W + 7) / 8) * 8;

    typedef logic [COORD_W-1:0] coord_t;

endpackage

`default_nettype wire

// File: hw/rtl/multitouch_slot_tracker.sv
`default_nettype none

// Channel   Dir  Beat fields (low bit up)                      Handshake
// s_*       in   tdata: finger, x_pos, y_pos; tuser: action    s_tvalid & s_tready
// m_*       out  tdata: slot, x_out, y_out, pad; tuser: pressed;
//                tlast: last                                    m_tvalid & m_tready
//
// Touch and release walk the finger-id memory through its single read port, one
// slot a cycle; the result then waits to be handed over while the output stalls.
// Release-inactive and release-all step over the flag registers, one slot a cycle
// unless a stalled output holds a slot to be freed. Clear-active clears every active
// flag and stays idle.
// Reset clears the enabled and active flags at once; the id memory is not cleared,
// since an entry is only compared while its enabled flag is set.
// A result waits in the output register while the next beat is taken; a stalled
// output holds the hand-off or the bulk walk until m_tready frees the register.

module multitouch_slot_tracker #(
    parameter int SLOT_COUNT = 16
) (
    input  wire                             clk,
    input  wire                             rst_n,

    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [mst_pkg::IN_DATA_W-1:0]   s_tdata,   // finger, x_pos, y_pos
    input  wire  [mst_pkg::ACTION_W-1:0]    s_tuser,   // action

    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [mst_pkg::OUT_DATA_W-1:0]  m_tdata,   // slot, x_out, y_out, zero pad
    output logic                            m_tuser,   // pressed
    output logic                            m_tlast    // last
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1) > 0 ? $clog2(SLOT_COUNT + 1) : 1;
    localparam int PAD_W = mst_pkg::OUT_DATA_W - mst_pkg::SLOT_W - 2 * mst_pkg::COORD_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;   // id lookup over the memory
    localparam logic [1:0] ST_PUT  = 2'd2;   // hand lookup result to output
    localparam logic [1:0] ST_BULK = 2'd3;   // bulk release walk

    // finger id store, one read port and one write port
    logic [mst_pkg::FINGER_W-1:0] finger_mem [SLOT_COUNT];
    logic [mst_pkg::FINGER_W-1:0] mem_q;
    logic [IDX_W-1:0]             rd_addr;
    logic                         mem_we;
    logic [IDX_W-1:0]             wr_addr;

    logic [1:0]                    state_reg, state_next;
    logic [SLOT_COUNT-1:0]         enabled_reg, enabled_next;
    logic [SLOT_COUNT-1:0]         active_reg, active_next;
    logic                          is_touch_reg, is_touch_next;
    logic                          only_inact_reg, only_inact_next;
    logic [mst_pkg::FINGER_W-1:0]  id_reg, id_next;
    mst_pkg::coord_t               x_reg, x_next, y_reg, y_next;
    logic [CNT_W-1:0]              scan_reg, scan_next;      // next address to read / bulk slot
    logic                          rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]              rd_idx_reg, rd_idx_next;  // slot that mem_q belongs to
    logic                          free_found_reg, free_found_next;
    logic [IDX_W-1:0]              free_idx_reg, free_idx_next;
    logic [mst_pkg::RES_CNT_W-1:0] n_reg, n_next;

    // pending lookup result
    logic [IDX_W-1:0]              res_slot_reg, res_slot_next;
    logic                          res_press_reg, res_press_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [mst_pkg::SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic                          out_press_reg, out_press_next;
    mst_pkg::coord_t               out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic                          out_last_reg, out_last_next;

    logic                          out_free;
    logic                          hit;
    logic                          scan_end;
    logic [SLOT_COUNT-1:0]         cand;
    logic [SLOT_COUNT-1:0]         above;
    logic [IDX_W-1:0]              bulk_idx;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            finger_mem[wr_addr] <= id_reg;
        end
        mem_q <= finger_mem[rd_addr];
    end

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign bulk_idx = scan_reg[IDX_W-1:0];

    assign hit      = rd_valid_reg && enabled_reg[rd_idx_reg] && (mem_q == id_reg);
    assign scan_end = rd_valid_reg && (hit || rd_idx_reg == IDX_W'(SLOT_COUNT - 1));

    // slots a bulk pass would free; freed slots lie below the walk, so live flags do
    assign cand = only_inact_reg ? (enabled_reg & ~active_reg) : enabled_reg;

    always_comb
    begin
        for (int j = 0; j < SLOT_COUNT; j++)
        begin
            above[j] = (CNT_W'(j) > scan_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        enabled_next    = enabled_reg;
        active_next     = active_reg;
        is_touch_next   = is_touch_reg;
        only_inact_next = only_inact_reg;
        id_next         = id_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        scan_next       = scan_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = rd_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        n_next          = n_reg;
        res_slot_next   = res_slot_reg;
        res_press_next  = res_press_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_slot_next   = out_slot_reg;
        out_press_next  = out_press_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_last_next   = out_last_reg;
        rd_addr         = scan_reg[IDX_W-1:0];
        mem_we          = 1'b0;
        wr_addr         = free_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    id_next         = s_tdata[mst_pkg::FINGER_W-1:0];
                    x_next          = s_tdata[mst_pkg::FINGER_W +: mst_pkg::COORD_W];
                    y_next          = s_tdata[mst_pkg::FINGER_W + mst_pkg::COORD_W +:
                                              mst_pkg::COORD_W];
                    scan_next       = '0;
                    free_found_next = 1'b0;
                    n_next          = '0;
                    unique case (s_tuser)
                        mst_pkg::ACT_TOUCH, mst_pkg::ACT_RELEASE:
                        begin
                            is_touch_next = (s_tuser == mst_pkg::ACT_TOUCH);
                            state_next    = ST_SCAN;
                        end
                        mst_pkg::ACT_CLEAR_ACTIVE:
                        begin
                            active_next = '0;
                        end
                        mst_pkg::ACT_RELEASE_INACTIVE, mst_pkg::ACT_RELEASE_ALL:
                        begin
                            only_inact_next = (s_tuser == mst_pkg::ACT_RELEASE_INACTIVE);
                            state_next      = ST_BULK;
                        end
                        default:
                        begin
                            // unused codes are dropped
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // issue reads ahead, compare the slot read in the last cycle
                if (scan_reg < CNT_W'(SLOT_COUNT))
                begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + 1'b1;
                end
                if (rd_valid_reg && !enabled_reg[rd_idx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = rd_idx_reg;
                end
                if (scan_end)
                begin
                    rd_valid_next = 1'b0;
                    state_next    = ST_IDLE;
                    if (is_touch_reg)
                    begin
                        if (hit)
                        begin
                            active_next[rd_idx_reg] = 1'b1;
                            res_slot_next           = rd_idx_reg;
                            res_press_next          = 1'b1;
                            state_next              = ST_PUT;
                        end
                        else if (free_found_reg || !enabled_reg[rd_idx_reg])
                        begin
                            // new finger takes the lowest free slot
                            wr_addr                 = free_found_reg ? free_idx_reg
                                                                     : rd_idx_reg;
                            mem_we                  = 1'b1;
                            enabled_next[wr_addr]   = 1'b1;
                            active_next[wr_addr]    = 1'b1;
                            res_slot_next           = wr_addr;
                            res_press_next          = 1'b1;
                            state_next              = ST_PUT;
                        end
                    end
                    else if (hit)
                    begin
                        enabled_next[rd_idx_reg] = 1'b0;
                        res_slot_next            = rd_idx_reg;
                        res_press_next           = 1'b0;
                        state_next               = ST_PUT;
                    end
                end
            end

            ST_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = mst_pkg::SLOT_W'(res_slot_reg);
                    out_press_next = res_press_reg;
                    out_x_next     = res_press_reg ? x_reg : '0;
                    out_y_next     = res_press_reg ? y_reg : '0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_BULK:
            begin
                if (scan_reg >= CNT_W'(SLOT_COUNT) ||
                    n_reg == mst_pkg::RES_CNT_W'(mst_pkg::RESULT_LIMIT))
                begin
                    state_next = ST_IDLE;
                end
                else if (!cand[bulk_idx])
                begin
                    scan_next = scan_reg + 1'b1;
                end
                else if (out_free)
                begin
                    enabled_next[bulk_idx] = 1'b0;
                    out_valid_next = 1'b1;
                    out_slot_next  = mst_pkg::SLOT_W'(bulk_idx);
                    out_press_next = 1'b0;
                    out_x_next     = '0;
                    out_y_next     = '0;
                    // last when the budget runs out or nothing is left above
                    out_last_next  = (n_reg == mst_pkg::RES_CNT_W'(mst_pkg::RESULT_LIMIT - 1))
                                     || ((cand & above) == '0);
                    n_next         = n_reg + 1'b1;
                    scan_next      = scan_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            enabled_reg    <= '0;
            active_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            enabled_reg    <= enabled_next;
            active_reg     <= active_next;
            rd_valid_reg   <= rd_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_touch_reg   <= is_touch_next;
        only_inact_reg <= only_inact_next;
        id_reg         <= id_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        scan_reg       <= scan_next;
        rd_idx_reg     <= rd_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        n_reg          <= n_next;
        res_slot_reg   <= res_slot_next;
        res_press_reg  <= res_press_next;
        out_slot_reg   <= out_slot_next;
        out_press_reg  <= out_press_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_y_reg, out_x_reg, out_slot_reg};
    assign m_tuser  = out_press_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: tb/tb_multitouch_slot_tracker.sv
module tb_multitouch_slot_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;

    // actions 5 to 7 carry no meaning and must be swallowed
    localparam int ACT_UNUSED_LO = 5;
    localparam int ACT_UNUSED_HI = 7;

    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_PER_PHASE = 100;

    typedef struct packed {
        logic [mst_pkg::ACTION_W-1:0] action;
        logic [mst_pkg::FINGER_W-1:0] finger;
        mst_pkg::coord_t              x;
        mst_pkg::coord_t              y;
    } touch_item_t;

    typedef struct packed {
        logic [mst_pkg::SLOT_W-1:0] slot;
        logic                       pressed;
        mst_pkg::coord_t            x;
        mst_pkg::coord_t            y;
        logic                       last;
    } slot_report_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;

    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [mst_pkg::IN_DATA_W-1:0]  s_tdata = '0;   // finger, x_pos, y_pos
    logic [mst_pkg::ACTION_W-1:0]   s_tuser = '0;   // action

    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [mst_pkg::OUT_DATA_W-1:0] m_tdata;        // slot, x_out, y_out, zero pad
    logic                           m_tuser;        // pressed
    logic                           m_tlast;        // last

    // shadow of the slot table
    logic                           shadow_enabled [SLOTS];
    logic                           shadow_active  [SLOTS];
    logic [mst_pkg::FINGER_W-1:0]   shadow_finger  [SLOTS];

    touch_item_t                    pending_items[$];
    slot_report_t                   due_reports[$];
    logic [mst_pkg::FINGER_W-1:0]   live_ids[$];
    touch_item_t                    on_bus = '0;

    int                             tx_idle_pct = 0;
    int                             rx_idle_pct = 0;
    logic                           hold_req = 1'b0;
    logic                           rx_hold = 1'b0;

    int                             mismatches = 0;
    int                             beats_taken = 0;
    int                             reports_seen = 0;
    int                             touches_dropped = 0;
    int                             bulk_frees = 0;

    multitouch_slot_tracker #(
        .SLOT_COUNT (SLOTS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_enabled[i] = 1'b0;
            shadow_active[i]  = 1'b0;
            shadow_finger[i]  = '0;
        end
    end

    task automatic note_mismatch(string msg);
        mismatches++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // lowest enabled slot holding this id, -1 if none
    function automatic int find_finger(logic [mst_pkg::FINGER_W-1:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (shadow_enabled[i] && shadow_finger[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void push_report(int s, logic pr, mst_pkg::coord_t x,
                                        mst_pkg::coord_t y, logic lst);
        slot_report_t r;
        r.slot    = s[mst_pkg::SLOT_W-1:0];
        r.pressed = pr;
        r.x       = x;
        r.y       = y;
        r.last    = lst;
        due_reports.push_back(r);
    endfunction

    // Advance the shadow table by one accepted beat and queue what it must produce.
    function automatic void track_slots(touch_item_t it);
        int  hit;
        int  freed;
        logic only_idle;
        hit = -1;
        freed = 0;
        only_idle = (it.action == mst_pkg::ACT_RELEASE_INACTIVE);
        case (it.action)
            mst_pkg::ACT_TOUCH:
            begin
                hit = find_finger(it.finger);
                if (hit < 0)
                begin
                    for (int i = 0; i < SLOTS && hit < 0; i++)
                        if (!shadow_enabled[i])
                            hit = i;
                    if (hit >= 0)
                    begin
                        shadow_enabled[hit] = 1'b1;
                        shadow_finger[hit]  = it.finger;
                    end
                end
                if (hit < 0)
                    touches_dropped++;      // table full, beat swallowed
                else
                begin
                    shadow_active[hit] = 1'b1;
                    push_report(hit, 1'b1, it.x, it.y, 1'b1);
                end
            end
            mst_pkg::ACT_RELEASE:
            begin
                hit = find_finger(it.finger);
                if (hit >= 0)
                begin
                    // active flag left as it is
                    shadow_enabled[hit] = 1'b0;
                    push_report(hit, 1'b0, '0, '0, 1'b1);
                end
            end
            mst_pkg::ACT_CLEAR_ACTIVE:
                for (int i = 0; i < SLOTS; i++)
                    shadow_active[i] = 1'b0;
            mst_pkg::ACT_RELEASE_INACTIVE, mst_pkg::ACT_RELEASE_ALL:
            begin
                for (int i = 0; i < SLOTS && freed < mst_pkg::RESULT_LIMIT; i++)
                    if (shadow_enabled[i] && !(only_idle && shadow_active[i]))
                    begin
                        shadow_enabled[i] = 1'b0;
                        push_report(i, 1'b0, '0, '0, 1'b0);
                        freed++;
                    end
                if (freed > 0)
                    due_reports[due_reports.size() - 1].last = 1'b1;
                bulk_frees += freed;
            end
            default: ;
        endcase
    endfunction

    // Driver: predicts on each accepted beat, then offers the next pending one.
    always @(posedge clk)
    begin : drive
        touch_item_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                track_slots(on_bus);
                beats_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    nxt = pending_items.pop_front();
                    on_bus   <= nxt;
                    s_tdata  <= {nxt.y, nxt.x, nxt.finger};
                    s_tuser  <= nxt.action;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result beat against the oldest prediction.
    always @(posedge clk)
    begin : watch
        slot_report_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                reports_seen++;
                if (due_reports.size() == 0)
                    note_mismatch($sformatf("result beat for slot %0d with none expected",
                                            m_tdata[mst_pkg::SLOT_W-1:0]));
                else
                begin
                    want = due_reports.pop_front();
                    compare_field("slot", 32'(m_tdata[mst_pkg::SLOT_W-1:0]),
                                  32'(want.slot));
                    compare_field("pressed", 32'(m_tuser), 32'(want.pressed));
                    compare_field("x_out", 32'(m_tdata[mst_pkg::SLOT_W +: mst_pkg::COORD_W]),
                                  32'(want.x));
                    compare_field("y_out",
                                  32'(m_tdata[mst_pkg::SLOT_W + mst_pkg::COORD_W +:
                                              mst_pkg::COORD_W]),
                                  32'(want.y));
                    compare_field("last", 32'(m_tlast), 32'(want.last));
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver hold-off so the output register and walk back up into s_tready.
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic queue_item(logic [mst_pkg::ACTION_W-1:0] act,
                              logic [mst_pkg::FINGER_W-1:0] id,
                              mst_pkg::coord_t x, mst_pkg::coord_t y);
        touch_item_t it;
        it.action = act;
        it.finger = id;
        it.x      = x;
        it.y      = y;
        pending_items.push_back(it);
    endtask

    // extremes get a fair share
    function automatic mst_pkg::coord_t rand_coord();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return mst_pkg::coord_t'($urandom);
    endfunction

    // Mostly plausible finger traffic: touches and moves of known ids, releases
    // of held ids, with stray releases, bulk commands and unused actions mixed in.
    task automatic queue_random(int n);
        int counted;
        int roll;
        int pick;
        logic [mst_pkg::FINGER_W-1:0] id;
        counted = 0;
        while (counted < n)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
            begin
                if (live_ids.size() > 0 && (live_ids.size() >= 20 || $urandom_range(1) == 1))
                    id = live_ids[$urandom_range(live_ids.size() - 1)];
                else
                begin
                    id = ($urandom_range(1) == 1) ? $urandom : $urandom_range(31);
                    live_ids.push_back(id);
                end
                queue_item(mst_pkg::ACT_TOUCH, id, rand_coord(), rand_coord());
            end
            else if (roll < 70)
            begin
                if (live_ids.size() > 0 && $urandom_range(4) != 0)
                begin
                    pick = $urandom_range(live_ids.size() - 1);
                    id = live_ids[pick];
                    live_ids.delete(pick);
                end
                else
                    id = $urandom;
                queue_item(mst_pkg::ACT_RELEASE, id, rand_coord(), rand_coord());
            end
            else if (roll < 80)
                queue_item(mst_pkg::ACT_CLEAR_ACTIVE, $urandom, rand_coord(), rand_coord());
            else if (roll < 88)
                queue_item(mst_pkg::ACT_RELEASE_INACTIVE, $urandom, rand_coord(),
                           rand_coord());
            else if (roll < 94)
            begin
                queue_item(mst_pkg::ACT_RELEASE_ALL, $urandom, rand_coord(), rand_coord());
                live_ids.delete();
            end
            else if (roll < 97)
            begin
                queue_item(mst_pkg::ACTION_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO)),
                           $urandom, rand_coord(), rand_coord());
                counted--;      // ignored beats do not count
            end
            else
            begin
                // burst of fresh fingers to push the table towards full
                for (int k = 0; k < 3; k++)
                begin
                    id = $urandom;
                    live_ids.push_back(id);
                    queue_item(mst_pkg::ACT_TOUCH, id, rand_coord(), rand_coord());
                    counted++;
                end
            end
            counted++;
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || due_reports.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phase 1: light sender gaps, heavy receiver stalls
        tx_idle_pct = 12;
        rx_idle_pct = 48;

        // directed: extremes, moves, stray release, clear and both bulk releases
        queue_item(mst_pkg::ACT_TOUCH, 32'h0000_0000, 16'h0000, 16'h0000);
        queue_item(mst_pkg::ACT_TOUCH, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        queue_item(mst_pkg::ACT_TOUCH, 32'h0000_0000, 16'h1234, 16'hABCD);   // move on slot 0
        queue_item(mst_pkg::ACT_RELEASE, 32'h0000_0005, 16'hFFFF, 16'hFFFF); // unknown id
        queue_item(mst_pkg::ACT_RELEASE, 32'hFFFF_FFFF, 16'h5555, 16'hAAAA);
        queue_item(mst_pkg::ACT_CLEAR_ACTIVE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        queue_item(mst_pkg::ACT_TOUCH, 32'h0000_0005, 16'h8000, 16'h0001);   // reuses freed slot
        queue_item(mst_pkg::ACT_RELEASE_INACTIVE, 32'h0, 16'h0, 16'h0);      // frees idle slot 0
        queue_item(mst_pkg::ACT_RELEASE_INACTIVE, 32'h0, 16'h0, 16'h0);      // nothing left idle
        queue_item(mst_pkg::ACTION_W'(ACT_UNUSED_LO), 32'h0000_0005, 16'hFFFF, 16'hFFFF);
        for (int k = 0; k < SLOTS - 1; k++)
            queue_item(mst_pkg::ACT_TOUCH, 32'h0000_0100 + k, rand_coord(), rand_coord());
        queue_item(mst_pkg::ACT_TOUCH, 32'hDEAD_0001, 16'hFFFF, 16'h0000);   // table full
        queue_item(mst_pkg::ACT_RELEASE_ALL, 32'h0, 16'h0, 16'h0);           // sixteen frees

        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        // phase 2: roles swapped
        @(negedge clk);
        tx_idle_pct = 48;
        rx_idle_pct = 12;
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        // phase 3: no idling, opened by the long receiver hold-off
        @(negedge clk);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        // a trailing beat with no result may still be walking the table
        repeat (SLOTS + 8) @(posedge clk);

        if (due_reports.size() != 0)
            note_mismatch($sformatf("%0d result beats never arrived", due_reports.size()));
        $display("Covered %0d input beats and %0d result beats under three stall mixes",
                 beats_taken, reports_seen);
        $display("  %0d touches dropped on a full table, %0d slots freed by bulk releases",
                 touches_dropped, bulk_frees);
        if (mismatches == 0)
            $display("tb_multitouch_slot_tracker: PASS");
        else
            $display("tb_multitouch_slot_tracker: FAIL");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #4_000_000;
        $display("Timeout with %0d beats pending and %0d results due",
                 pending_items.size(), due_reports.size());
        $display("tb_multitouch_slot_tracker: FAIL");
        $finish;
    end

endmodule
